// File: hdl/aes_cmac_tag_engine_assert.svh
// assertion macros for the cmac tag engine
`ifndef AES_CMAC_TAG_ENGINE_ASSERT_SVH
`define AES_CMAC_TAG_ENGINE_ASSERT_SVH
// implication checked at every rising clock edge outside reset
`define ACTE_ASSERT_IMP(lbl, clk, rst_n, a, c) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (c)) \
        else $error("assertion failed");
// next-cycle implication
`define ACTE_ASSERT_NXT(lbl, clk, rst_n, a, c) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (c)) \
        else $error("assertion failed");
`endif

// File: hdl/acte_pkg.sv
// package: aes tables, round helpers and shared types
`default_nettype none
package acte_pkg;
    localparam int BlockBytes = 16;
    localparam logic [7:0] PadMark = 8'h80;
    localparam logic [7:0] RbConst = 8'h87;
    localparam int NumRounds = 10;

    // configuration register indexes
    localparam logic CfgKeyHigh = 1'b0;
    localparam logic CfgKeyLow = 1'b1;

    typedef logic [127:0] t_block;
    typedef logic [3:0] t_round;

    typedef struct packed {
        logic   start;
        t_block din;
        t_block rkey;
    } t_rnd_ctl;

    function automatic logic [7:0] sbox(input logic [7:0] x);
        logic [7:0] t [256];
        t = '{
        8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
        8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
        8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
        8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
        8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
        8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
        8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
        8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
        8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
        8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
        8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
        8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
        8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
        8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
        8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
        8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16};
        return t[x];
    endfunction

    function automatic logic [7:0] rcon(input t_round r);
        logic [7:0] v;
        case (r)
            4'd1: v = 8'h01;
            4'd2: v = 8'h02;
            4'd3: v = 8'h04;
            4'd4: v = 8'h08;
            4'd5: v = 8'h10;
            4'd6: v = 8'h20;
            4'd7: v = 8'h40;
            4'd8: v = 8'h80;
            4'd9: v = 8'h1b;
            4'd10: v = 8'h36;
            default: v = 8'h00;
        endcase
        return v;
    endfunction

    function automatic logic [7:0] xtime(input logic [7:0] x);
        return {x[6:0], 1'b0} ^ (x[7] ? 8'h1b : 8'h00);
    endfunction

    // byte i of a block, byte 0 most significant
    function automatic logic [7:0] bget(input t_block b, input int i);
        return b[127 - 8 * i -: 8];
    endfunction

    // next round key from the previous one
    function automatic t_block next_key(input t_block k, input t_round r);
        logic [31:0] w0, w1, w2, w3, t;
        w0 = k[127:96];
        w1 = k[95:64];
        w2 = k[63:32];
        w3 = k[31:0];
        t = {sbox(w3[23:16]) ^ rcon(r), sbox(w3[15:8]), sbox(w3[7:0]), sbox(w3[31:24])};
        w0 = w0 ^ t;
        w1 = w1 ^ w0;
        w2 = w2 ^ w1;
        w3 = w3 ^ w2;
        return {w0, w1, w2, w3};
    endfunction

    // gf(2^128) doubling with rb reduction
    function automatic t_block dbl(input t_block x);
        t_block y;
        y = {x[126:0], 1'b0};
        y[7:0] = y[7:0] ^ (x[127] ? RbConst : 8'h00);
        return y;
    endfunction
endpackage
`default_nettype wire

// File: hdl/aes_cmac_tag_engine.sv
// aes-128 cmac tag engine top level
// the tag is registered from the round state after the last round; the first block after
// reset or a key write waits while the subkeys are derived; a new block is accepted only
// once the previous one is done, and after a last block only once its result is taken
// the shared round unit does one aes round per cycle and computes round keys on the fly
// synchronous active-low reset clears chain value, key and subkey-valid flag
`default_nettype none
`include "aes_cmac_tag_engine_assert.svh"
module aes_cmac_tag_engine (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_cfg_we,
    input  wire logic        i_cfg_idx,
    input  wire logic [63:0] i_cfg_data,
    input  wire logic        i_valid,
    output logic             o_ready,
    input  wire logic        i_mode,
    input  wire logic [63:0] i_data_high,
    input  wire logic [63:0] i_data_low,
    input  wire logic [4:0]  i_byte_count,
    input  wire logic        i_last_block,
    input  wire logic [63:0] i_expected_high,
    input  wire logic [63:0] i_expected_low,
    output logic             o_valid,
    input  wire logic        i_ready,
    output logic [63:0]      o_tag_high,
    output logic [63:0]      o_tag_low,
    output logic             o_tag_match
);
    typedef enum logic [2:0] {S_IDLE, S_SUBK, S_RUN, S_DONE} t_state;

    t_state r_st;
    acte_pkg::t_block r_key, r_chain, r_k1, r_k2, r_blk, r_exp, msg;
    logic r_mode, r_last, r_ready_flag, r_first;
    acte_pkg::t_rnd_ctl ctl;
    acte_pkg::t_block rs;
    logic rlast;
    logic [4:0] cnt;
    acte_pkg::t_block l1;
    acte_pkg::t_block r_padded;
    logic [4:0] r_cnt;

    acte_round u_round (.i_clk(i_clk), .i_ctl(ctl), .o_state(rs), .o_last(rlast));

    wire acc = i_valid && o_ready;

    // pad and whiten the last block, then xor every block with the chain value
    always_comb begin
        cnt = (i_byte_count > 5'd16) ? 5'd16 : i_byte_count;
        msg = {i_data_high, i_data_low};
        if (!i_last_block) begin
            msg = msg;
        end else if (cnt == 5'd16) begin
            msg = msg ^ r_k1;
        end else begin
            for (int i = 0; i < acte_pkg::BlockBytes; i++) begin
                if (i == int'(cnt)) msg[127 - 8 * i -: 8] = acte_pkg::PadMark;
                else if (i > int'(cnt)) msg[127 - 8 * i -: 8] = 8'h00;
            end
            msg = msg ^ r_k2;
        end
        msg = msg ^ r_chain;
        l1 = acte_pkg::dbl(rs);
    end

    // late pad path, using stored beat and fresh subkeys
    always_ff @(posedge i_clk) begin
        if (acc) r_cnt <= cnt;
    end
    always_comb begin
        r_padded = r_blk;
        if (r_cnt == 5'd16) begin
            r_padded = r_padded ^ r_k1;
        end else begin
            for (int i = 0; i < acte_pkg::BlockBytes; i++) begin
                if (i == int'(r_cnt)) r_padded[127 - 8 * i -: 8] = acte_pkg::PadMark;
                else if (i > int'(r_cnt)) r_padded[127 - 8 * i -: 8] = 8'h00;
            end
            r_padded = r_padded ^ r_k2;
        end
        r_padded = r_padded ^ r_chain;
    end

    always_comb begin
        ctl.start = 1'b0;
        ctl.din = r_blk;
        ctl.rkey = r_key;
        if (r_st == S_IDLE && acc && !r_ready_flag) begin
            ctl.start = 1'b1;
            ctl.din = '0;
        end else if (r_st == S_IDLE && acc) begin
            ctl.start = 1'b1;
            ctl.din = msg;
        end else if (r_first) begin
            ctl.start = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st <= S_IDLE;
            r_key <= '0;
            r_chain <= '0;
            r_ready_flag <= 1'b0;
            r_first <= 1'b0;
            o_valid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                if (i_cfg_idx == acte_pkg::CfgKeyHigh) r_key[127:64] <= i_cfg_data;
                else r_key[63:0] <= i_cfg_data;
                r_ready_flag <= 1'b0;
            end
            unique case (r_st)
                S_IDLE: if (acc) begin
                    r_mode <= i_mode;
                    r_last <= i_last_block;
                    r_exp <= {i_expected_high, i_expected_low};
                    r_blk <= {i_data_high, i_data_low};
                    r_st <= r_ready_flag ? S_RUN : S_SUBK;
                end
                S_SUBK: if (rlast) begin
                    r_k1 <= l1;
                    r_k2 <= acte_pkg::dbl(l1);
                    r_ready_flag <= 1'b1;
                    if (r_last) begin
                        r_st <= S_DONE;
                    end else begin
                        // chain the stored middle block now that subkeys exist
                        r_blk <= r_blk ^ r_chain;
                        r_first <= 1'b1;
                        r_st <= S_RUN;
                    end
                end
                S_DONE: begin
                    // last block seen during subkey setup: pad it here
                    r_blk <= r_padded;
                    r_first <= 1'b1;
                    r_st <= S_RUN;
                end
                S_RUN: if (r_first) begin
                    r_first <= 1'b0;
                end else if (rlast) begin
                    if (r_last) begin
                        r_chain <= '0;
                        o_valid <= 1'b1;
                        o_tag_high <= rs[127:64];
                        o_tag_low <= rs[63:0];
                        o_tag_match <= r_mode && (rs == r_exp);
                        r_st <= S_IDLE;
                    end else begin
                        r_chain <= rs;
                        r_st <= S_IDLE;
                    end
                end
                default: r_st <= S_IDLE;
            endcase
            if (o_valid && i_ready) o_valid <= 1'b0;
        end
    end

    assign o_ready = (r_st == S_IDLE) && !o_valid;

    `ACTE_ASSERT_IMP(a_busy_not_ready, i_clk, i_rst_n, r_st != S_IDLE, !o_ready)
    `ACTE_ASSERT_NXT(a_out_holds, i_clk, i_rst_n, o_valid && !i_ready, o_valid && $stable(o_tag_high))
    `ACTE_ASSERT_IMP(a_match_gen, i_clk, i_rst_n, o_valid && !r_mode, !o_tag_match)
endmodule
`default_nettype wire

// File: hdl/acte_round.sv
// shared aes round unit: one round per cycle, key schedule alongside
`default_nettype none
module acte_round (
    input  wire logic              i_clk,
    input  wire acte_pkg::t_rnd_ctl i_ctl,
    output acte_pkg::t_block       o_state,
    output logic                   o_last
);
    acte_pkg::t_block r_state, r_rkey, n_state, n_rkey, s, t;
    acte_pkg::t_round r_rnd, n_rnd;
    logic [7:0] a0, a1, a2, a3, al;

    always_comb begin
        s = r_state;
        t = '0;
        a0 = '0;
        a1 = '0;
        a2 = '0;
        a3 = '0;
        al = '0;
        for (int i = 0; i < 16; i++)
            t[127 - 8 * i -: 8] = acte_pkg::sbox(acte_pkg::bget(s, i));
        for (int c = 0; c < 4; c++)
            for (int i = 0; i < 4; i++)
                s[127 - 8 * (i + 4 * c) -: 8] = acte_pkg::bget(t, i + 4 * ((c + i) & 3));
        if (r_rnd != acte_pkg::t_round'(acte_pkg::NumRounds - 1)) begin
            for (int c = 0; c < 4; c++) begin
                a0 = acte_pkg::bget(s, 4 * c);
                a1 = acte_pkg::bget(s, 4 * c + 1);
                a2 = acte_pkg::bget(s, 4 * c + 2);
                a3 = acte_pkg::bget(s, 4 * c + 3);
                al = a0 ^ a1 ^ a2 ^ a3;
                s[127 - 8 * (4 * c) -: 8] = a0 ^ al ^ acte_pkg::xtime(a0 ^ a1);
                s[127 - 8 * (4 * c + 1) -: 8] = a1 ^ al ^ acte_pkg::xtime(a1 ^ a2);
                s[127 - 8 * (4 * c + 2) -: 8] = a2 ^ al ^ acte_pkg::xtime(a2 ^ a3);
                s[127 - 8 * (4 * c + 3) -: 8] = a3 ^ al ^ acte_pkg::xtime(a3 ^ a0);
            end
        end
        n_rkey = acte_pkg::next_key(r_rkey, r_rnd + 4'd1);
        n_state = s ^ n_rkey;
        n_rnd = r_rnd + 4'd1;
        if (i_ctl.start) begin
            n_state = i_ctl.din ^ i_ctl.rkey;
            n_rkey = i_ctl.rkey;
            n_rnd = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        r_state <= n_state;
        r_rkey <= n_rkey;
        r_rnd <= n_rnd;
    end

    assign o_state = r_state;
    assign o_last = (r_rnd == acte_pkg::t_round'(acte_pkg::NumRounds));
endmodule
`default_nettype wire

// File: tb/testbench.sv
// self-checking testbench for the aes-128 cmac tag engine
`default_nettype none
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int   DRAIN_CYCLES = 40;
    localparam int   RANDOM_BEATS = 1300;

    typedef enum logic [1:0] {ROW_BEAT, ROW_KEY_HIGH, ROW_KEY_LOW} t_row_kind;

    typedef struct {
        t_row_kind   kind;
        logic        mode;
        logic [63:0] dh;
        logic [63:0] dl;
        logic [4:0]  cnt;
        logic        last;
        logic [63:0] eh;
        logic [63:0] el;
        bit          typed;
        logic [63:0] th;
        logic [63:0] tl;
        logic        tm;
    } t_dir_row;

    typedef struct {
        logic [63:0] th;
        logic [63:0] tl;
        logic        tm;
    } t_tag;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_cfg_we = 1'b0;
    logic        i_cfg_idx = 1'b0;
    logic [63:0] i_cfg_data = '0;
    logic        i_valid = 1'b0;
    logic        o_ready;
    logic        i_mode = 1'b0;
    logic [63:0] i_data_high = '0;
    logic [63:0] i_data_low = '0;
    logic [4:0]  i_byte_count = '0;
    logic        i_last_block = 1'b0;
    logic [63:0] i_expected_high = '0;
    logic [63:0] i_expected_low = '0;
    logic        o_valid;
    logic        i_ready = 1'b0;
    logic [63:0] o_tag_high;
    logic [63:0] o_tag_low;
    logic        o_tag_match;

    aes_cmac_tag_engine u_top (.*);

    always #4 i_clk = ~i_clk;

    // cmac model state
    bit [7:0]   sbox_tab [256] = '{
        8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
        8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
        8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
        8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
        8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
        8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
        8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
        8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
        8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
        8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
        8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
        8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
        8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
        8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
        8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
        8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16};
    bit [7:0]   rcon_tab [10] = '{8'h01,8'h02,8'h04,8'h08,8'h10,8'h20,8'h40,8'h80,8'h1b,8'h36};
    bit [127:0] key_reg;
    bit [127:0] chain_reg;
    bit [127:0] sub_k1, sub_k2;
    bit [127:0] round_keys [11];
    bit         keys_valid;

    t_tag tag_q [$];
    int   send_idle_pct, recv_idle_pct;
    int   beats_sent, tags_seen, match_seen, fails;
    bit   timed_out;

    function automatic bit [7:0] gf_x2(bit [7:0] x);
        return {x[6:0], 1'b0} ^ (x[7] ? 8'h1b : 8'h00);
    endfunction

    function automatic void expand_key();
        bit [7:0] w [176];
        bit [7:0] t [4];
        bit [7:0] u;
        for (int i = 0; i < 16; i++) w[i] = key_reg[127 - 8 * i -: 8];
        for (int i = 16; i < 176; i += 4) begin
            for (int k = 0; k < 4; k++) t[k] = w[i - 4 + k];
            if (i % 16 == 0) begin
                u = t[0];
                t[0] = sbox_tab[t[1]] ^ rcon_tab[i / 16 - 1];
                t[1] = sbox_tab[t[2]];
                t[2] = sbox_tab[t[3]];
                t[3] = sbox_tab[u];
            end
            for (int k = 0; k < 4; k++) w[i + k] = w[i - 16 + k] ^ t[k];
        end
        for (int r = 0; r < 11; r++)
            for (int i = 0; i < 16; i++) round_keys[r][127 - 8 * i -: 8] = w[16 * r + i];
    endfunction

    function automatic bit [127:0] aes_encrypt(bit [127:0] pt);
        bit [7:0]   s [16];
        bit [7:0]   t [16];
        bit [7:0]   a0, a1, a2, a3, all;
        bit [127:0] ct;
        for (int i = 0; i < 16; i++) s[i] = pt[127 - 8 * i -: 8] ^ round_keys[0][127 - 8 * i -: 8];
        for (int r = 1; r <= 10; r++) begin
            for (int i = 0; i < 16; i++) t[i] = sbox_tab[s[i]];
            for (int c = 0; c < 4; c++)
                for (int i = 0; i < 4; i++) s[i + 4 * c] = t[i + 4 * ((c + i) % 4)];
            if (r < 10) begin
                for (int c = 0; c < 4; c++) begin
                    a0 = s[4 * c]; a1 = s[4 * c + 1]; a2 = s[4 * c + 2]; a3 = s[4 * c + 3];
                    all = a0 ^ a1 ^ a2 ^ a3;
                    s[4 * c]     = a0 ^ all ^ gf_x2(a0 ^ a1);
                    s[4 * c + 1] = a1 ^ all ^ gf_x2(a1 ^ a2);
                    s[4 * c + 2] = a2 ^ all ^ gf_x2(a2 ^ a3);
                    s[4 * c + 3] = a3 ^ all ^ gf_x2(a3 ^ a0);
                end
            end
            for (int i = 0; i < 16; i++) s[i] ^= round_keys[r][127 - 8 * i -: 8];
        end
        for (int i = 0; i < 16; i++) ct[127 - 8 * i -: 8] = s[i];
        return ct;
    endfunction

    function automatic bit [127:0] double128(bit [127:0] x);
        return {x[126:0], 1'b0} ^ (x[127] ? 128'h87 : 128'h0);
    endfunction

    // advances the chain; returns 1 with the tag when the beat ends a message
    function automatic bit cmac_advance(input logic [63:0] dh, input logic [63:0] dl,
                                        input logic [4:0] cnt, input logic last,
                                        output bit [127:0] tag);
        bit [127:0] blk;
        int         n;
        if (!keys_valid) begin
            expand_key();
            sub_k1 = double128(aes_encrypt('0));
            sub_k2 = double128(sub_k1);
            keys_valid = 1;
        end
        blk = {dh, dl};
        if (!last) begin
            chain_reg = aes_encrypt(chain_reg ^ blk);
            return 0;
        end
        n = (cnt > 16) ? 16 : cnt;
        if (n == 16) begin
            blk ^= sub_k1;
        end else begin
            blk[127 - 8 * n -: 8] = 8'h80;
            for (int i = n + 1; i < 16; i++) blk[127 - 8 * i -: 8] = 8'h00;
            blk ^= sub_k2;
        end
        tag = aes_encrypt(chain_reg ^ blk);
        chain_reg = '0;
        return 1;
    endfunction

    task automatic write_key(input logic idx, input logic [63:0] val);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= val;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        @(posedge i_clk);
        if (idx == acte_pkg::CfgKeyHigh) key_reg[127:64] = val;
        else key_reg[63:0] = val;
        keys_valid = 0;
    endtask

    // wait for every tag, then let a block with no tag finish
    task automatic drain();
        i_valid <= 1'b0;
        while (tag_q.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic send_beat(input logic mode, input logic [63:0] dh, input logic [63:0] dl,
                             input logic [4:0] cnt, input logic last,
                             input logic [63:0] eh, input logic [63:0] el,
                             input bit has, input t_tag exp);
        if ($urandom_range(99) < send_idle_pct) begin
            i_valid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge i_clk);
        end
        i_valid         <= 1'b1;
        i_mode          <= mode;
        i_data_high     <= dh;
        i_data_low      <= dl;
        i_byte_count    <= cnt;
        i_last_block    <= last;
        i_expected_high <= eh;
        i_expected_low  <= el;
        do @(posedge i_clk); while (!o_ready);
        beats_sent++;
        if (has) tag_q.push_back(exp);
    endtask

    // result side: random stalls, one long hold-off to back the block up
    initial begin
        int  hold_left;
        bit  held;
        t_tag e;
        hold_left = 0;
        held = 0;
        forever begin
            @(posedge i_clk);
            if (i_rst_n && o_valid && i_ready) begin
                tags_seen++;
                if (o_tag_match) match_seen++;
                if (tag_q.size() == 0) begin
                    $error("tag beat with nothing expected");
                    fails++;
                end else begin
                    e = tag_q.pop_front();
                    if (o_tag_high !== e.th) begin
                        $error("tag_high exp %h got %h", e.th, o_tag_high);
                        fails++;
                    end
                    if (o_tag_low !== e.tl) begin
                        $error("tag_low exp %h got %h", e.tl, o_tag_low);
                        fails++;
                    end
                    if (o_tag_match !== e.tm) begin
                        $error("tag_match exp %b got %b", e.tm, o_tag_match);
                        fails++;
                    end
                end
            end
            if (!held && beats_sent >= 300) begin
                held = 1;
                hold_left = 600;
            end
            if (hold_left > 0) begin
                hold_left--;
                i_ready <= 1'b0;
            end else begin
                i_ready <= ($urandom_range(99) >= recv_idle_pct);
            end
        end
    end

    initial begin
        #20_000_000;
        timed_out = 1;
        $display("CHECKS FAILED");
        $finish;
    end

    initial begin
        t_dir_row   rows [$];
        logic [63:0] tag16_h, tag16_l;
        logic [63:0] eh, el, dh, dl;
        logic [4:0] cnt;
        logic       mode, last;
        bit [127:0] tag;
        bit         has;
        t_tag       exp;
        int         blocks, roll;
        logic [63:0] phase_keys [3][2];

        tag16_h = 64'h070a16b46b4d4144;
        tag16_l = 64'hf79bdd9dd04a287c;
        rows = '{
            '{ROW_KEY_HIGH, 0, 64'h2b7e151628aed2a6, 0, 0, 0, 0, 0, 0, 0, 0, 0},
            '{ROW_KEY_LOW,  0, 64'habf7158809cf4f3c, 0, 0, 0, 0, 0, 0, 0, 0, 0},
            // empty message
            '{ROW_BEAT, 0, 0, 0, 5'd0, 1, 0, 0, 1,
              64'hbb1d6929e9593728, 64'h7fa37d129b756746, 0},
            '{ROW_BEAT, 0, 64'h6bc1bee22e409f96, 64'he93d7e117393172a, 5'd16, 1, 0, 0, 1,
              tag16_h, tag16_l, 0},
            // verify: correct tag, then a wrong one
            '{ROW_BEAT, 1, 64'h6bc1bee22e409f96, 64'he93d7e117393172a, 5'd16, 1,
              tag16_h, tag16_l, 1, tag16_h, tag16_l, 1},
            '{ROW_BEAT, 1, 64'h6bc1bee22e409f96, 64'he93d7e117393172a, 5'd16, 1,
              tag16_h, ~tag16_l, 1, tag16_h, tag16_l, 0},
            // counts above a block saturate, then partial last blocks
            '{ROW_BEAT, 0, '1, '1, 5'd31, 1, 0, 0, 0, 0, 0, 0},
            '{ROW_BEAT, 1, '1, '1, 5'd17, 1, '1, '1, 0, 0, 0, 0},
            '{ROW_BEAT, 0, '1, '1, 5'd15, 1, 0, 0, 0, 0, 0, 0},
            '{ROW_BEAT, 0, '1, '1, 5'd1, 1, 0, 0, 0, 0, 0, 0},
            // count on a middle block is ignored
            '{ROW_BEAT, 0, '1, 0, 5'd0, 0, 0, 0, 0, 0, 0, 0},
            '{ROW_BEAT, 0, '1, '1, 5'd31, 0, 0, 0, 0, 0, 0, 0},
            '{ROW_BEAT, 1, 0, '1, 5'd5, 1, '1, 0, 0, 0, 0, 0},
            '{ROW_KEY_HIGH, 0, '1, 0, 0, 0, 0, 0, 0, 0, 0, 0},
            '{ROW_KEY_LOW,  0, '1, 0, 0, 0, 0, 0, 0, 0, 0, 0},
            '{ROW_BEAT, 0, 64'h0123456789abcdef, 64'hfedcba9876543210, 5'd8, 1, 0, 0, 0, 0, 0, 0},
            // key change in the middle of a message
            '{ROW_BEAT, 0, 64'h5555aaaa5555aaaa, 64'haaaa5555aaaa5555, 5'd16, 0, 0, 0, 0, 0, 0, 0},
            '{ROW_KEY_HIGH, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0},
            '{ROW_KEY_LOW,  0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0},
            '{ROW_BEAT, 0, 64'h8000000000000001, 1, 5'd16, 1, 0, 0, 0, 0, 0, 0},
            '{ROW_BEAT, 0, 0, 0, 5'd0, 1, 0, 0, 0, 0, 0, 0}
        };
        phase_keys = '{'{'1, '1}, '{'0, '0},
                       '{{$urandom, $urandom}, {$urandom, $urandom}}};

        key_reg = '0;
        chain_reg = '0;
        keys_valid = 0;
        send_idle_pct = 0;
        recv_idle_pct = 0;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (rows[r]) begin
            if (rows[r].kind == ROW_BEAT) begin
                has = cmac_advance(rows[r].dh, rows[r].dl, rows[r].cnt, rows[r].last, tag);
                if (rows[r].typed) exp = '{rows[r].th, rows[r].tl, rows[r].tm};
                else exp = '{tag[127:64], tag[63:0],
                             rows[r].mode && tag == {rows[r].eh, rows[r].el}};
                send_beat(rows[r].mode, rows[r].dh, rows[r].dl, rows[r].cnt, rows[r].last,
                          rows[r].eh, rows[r].el, has, exp);
            end else begin
                drain();
                write_key(rows[r].kind == ROW_KEY_HIGH ? acte_pkg::CfgKeyHigh
                                                       : acte_pkg::CfgKeyLow,
                          rows[r].dh);
            end
        end

        for (int p = 0; p < 3; p++) begin
            drain();
            write_key(acte_pkg::CfgKeyHigh, phase_keys[p][0]);
            write_key(acte_pkg::CfgKeyLow, phase_keys[p][1]);
            send_idle_pct = (p == 0) ? 25 : (p == 1) ? 60 : 0;
            recv_idle_pct = (p == 0) ? 60 : (p == 1) ? 25 : 0;
            while (beats_sent < 22 + (p + 1) * RANDOM_BEATS / 3) begin
                blocks = $urandom_range(1, 4);
                for (int b = 1; b <= blocks; b++) begin
                    last = (b == blocks);
                    dh = {$urandom, $urandom};
                    dl = {$urandom, $urandom};
                    roll = $urandom_range(9);
                    cnt = (roll < 4) ? 5'd16 : (roll == 4) ? 5'd0 : 5'($urandom_range(31));
                    mode = $urandom_range(1);
                    has = cmac_advance(dh, dl, cnt, last, tag);
                    roll = $urandom_range(9);
                    if (roll < 5) begin
                        {eh, el} = tag;
                    end else if (roll < 8) begin
                        {eh, el} = tag ^ (128'h1 << $urandom_range(127));
                    end else begin
                        eh = {$urandom, $urandom};
                        el = {$urandom, $urandom};
                    end
                    exp = '{tag[127:64], tag[63:0], mode && tag == {eh, el}};
                    send_beat(mode, dh, dl, cnt, last, eh, el, has, exp);
                end
            end
        end

        drain();
        $display("sent %0d beats over four keys and three stall patterns", beats_sent);
        $display("checked %0d tags, %0d of them verify matches", tags_seen, match_seen);
        if (fails == 0 && !timed_out) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end
endmodule
`default_nettype wire
